/* hdl/ise_pkg.sv */
// Shared types and constants of the indexed stack engine.
`timescale 1ns / 1ps
`default_nettype none
package ise_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int POS_W      = 5;
	localparam int FUNC_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int CAP_W      = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_INSERT = 3'd2,
		FN_REMOVE = 3'd3,
		FN_READ   = 3'd4,
		FN_WRITE  = 3'd5,
		FN_SWAP   = 3'd6,
		FN_SEARCH = 3'd7
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_LOAD_VALUE = 3'd1,
		CELL_LOAD_ALT   = 3'd2,
		CELL_FROM_BELOW = 3'd3,
		CELL_FROM_ABOVE = 3'd4,
		CELL_CLEAR      = 3'd5
	} cell_op_t;

	typedef struct packed {
		logic                  en;
		func_t                 func;
		logic [POS_W-1:0]      pos_a;
		logic [POS_W-1:0]      pos_b;
		logic [POS_W-1:0]      fill;
		logic [DATA_WIDTH-1:0] value;
	} chain_cmd_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] word_a;
		logic [DATA_WIDTH-1:0] word_top;
		logic [DEPTH-1:0]      match;
	} chain_rsp_t;

endpackage
`default_nettype wire

/* hdl/indexed_stack_engine.sv */
// Top level of the indexed stack engine: handshakes, sequencing and result register.
`timescale 1ns / 1ps
`default_nettype none
// A bounded stack of 16 words of 32 bits, addressed by 1-based position from
// the bottom and held in a row of cells that shift in parallel. Each input
// transaction is accepted while the block is idle and executed once the output
// register is free, so an operation other than search yields one result. A
// search yields one result when nothing matches; otherwise it yields one result
// for each hit, the hits leaving in ascending position order from a latched
// match vector. A result held in the output register that is not taken stalls
// execution, and no new input transaction is accepted until execution ends.
// The capacity register may be written at any time the block is idle; its port
// is always ready.
module indexed_stack_engine
	import ise_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CAP_W-1:0]      capacity,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [POS_W-1:0]      position_a,
	input  wire logic [POS_W-1:0]      position_b,
	input  wire logic [DATA_WIDTH-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic [DATA_WIDTH-1:0]      data_out,
	output logic [POS_W-1:0]           match_position,
	output logic                       found,
	output logic [POS_W-1:0]           fill_level,
	output logic                       last
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_SEARCH = 3'b100
	} state_t;

	state_t                state_q;
	logic [CAP_W-1:0]      capacity_q;
	logic [POS_W-1:0]      fill_q;
	logic [DEPTH-1:0]      pending_q;
	logic [FUNC_W-1:0]     func_q;
	logic [POS_W-1:0]      pos_a_q;
	logic [POS_W-1:0]      pos_b_q;
	logic [DATA_WIDTH-1:0] value_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	logic [POS_W-1:0]      match_position_q;
	logic                  found_q;
	logic [POS_W-1:0]      fill_level_q;
	logic                  last_q;

	chain_cmd_t            cmd;
	chain_rsp_t            rsp;
	func_t                 fn;
	status_t               exec_status;
	logic [POS_W-1:0]      fill_next;
	logic [DATA_WIDTH-1:0] exec_data;
	logic [POS_W-1:0]      usable_cap;
	logic                  is_full;
	logic                  is_empty;
	logic                  a_ok;
	logic                  b_ok;
	logic                  ins_ok;
	logic                  slot_free;
	logic                  exec_go;
	logic [DEPTH-1:0]      low_bit;
	logic [DEPTH-1:0]      pending_rest;
	logic [POS_W-1:0]      hit_pos;

	assign fn        = func_t'(func_q);
	assign slot_free = !out_valid_q || out_ready;
	assign exec_go   = (state_q == S_EXEC) && slot_free;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign usable_cap = (capacity_q > CAP_W'(DEPTH)) ? POS_W'(DEPTH) : POS_W'(capacity_q);
	assign is_full    = fill_q >= usable_cap;
	assign is_empty   = (fill_q == '0);
	assign a_ok       = (pos_a_q != '0) && (pos_a_q <= fill_q);
	assign b_ok       = (pos_b_q != '0) && (pos_b_q <= fill_q);
	assign ins_ok     = (pos_a_q != '0) &&
	                    ({1'b0, pos_a_q} <= ({1'b0, fill_q} + (POS_W+1)'(1)));

	always_comb begin
		exec_status = ST_OK;
		fill_next   = fill_q;
		exec_data   = '0;
		unique case (fn)
			FN_PUSH: begin
				if (is_full) begin
					exec_status = ST_FULL;
				end else begin
					fill_next = fill_q + POS_W'(1);
				end
			end
			FN_POP: begin
				if (is_empty) begin
					exec_status = ST_EMPTY;
				end else begin
					fill_next = fill_q - POS_W'(1);
					exec_data = rsp.word_top;
				end
			end
			FN_INSERT: begin
				if (is_full) begin
					exec_status = ST_FULL;
				end else if (!ins_ok) begin
					exec_status = ST_BADPOS;
				end else begin
					fill_next = fill_q + POS_W'(1);
				end
			end
			FN_REMOVE: begin
				if (is_empty) begin
					exec_status = ST_EMPTY;
				end else if (!a_ok) begin
					exec_status = ST_BADPOS;
				end else begin
					fill_next = fill_q - POS_W'(1);
				end
			end
			FN_READ: begin
				if (!a_ok) begin
					exec_status = ST_BADPOS;
				end else begin
					exec_data = rsp.word_a;
				end
			end
			FN_WRITE: begin
				if (!a_ok) exec_status = ST_BADPOS;
			end
			FN_SWAP: begin
				if (!a_ok || !b_ok) exec_status = ST_BADPOS;
			end
			FN_SEARCH: exec_status = ST_OK;
			default:   exec_status = ST_OK;
		endcase
	end

	assign cmd.en    = exec_go && (exec_status == ST_OK);
	assign cmd.func  = fn;
	assign cmd.pos_a = pos_a_q;
	assign cmd.pos_b = pos_b_q;
	assign cmd.fill  = fill_q;
	assign cmd.value = value_q;

	ise_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	assign low_bit      = pending_q & (~pending_q + DEPTH'(1));
	assign pending_rest = pending_q & ~low_bit;

	always_comb begin
		hit_pos = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (low_bit[k]) hit_pos = POS_W'(k + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= capacity;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q  <= func;
			pos_a_q <= position_a;
			pos_b_q <= position_b;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			pending_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (slot_free) begin
						fill_q <= fill_next;
						if (fn == FN_SEARCH && rsp.match != '0) begin
							pending_q <= rsp.match;
							state_q   <= S_SEARCH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SEARCH: begin
					if (slot_free) begin
						pending_q <= pending_rest;
						if (pending_rest == '0) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go && !(fn == FN_SEARCH && rsp.match != '0)) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_SEARCH && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q         <= exec_status;
			data_out_q       <= exec_data;
			match_position_q <= '0;
			found_q          <= 1'b0;
			fill_level_q     <= fill_next;
			last_q           <= 1'b1;
		end else if (state_q == S_SEARCH && slot_free) begin
			status_q         <= ST_OK;
			data_out_q       <= '0;
			match_position_q <= hit_pos;
			found_q          <= 1'b1;
			fill_level_q     <= fill_q;
			last_q           <= (pending_rest == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign data_out       = data_out_q;
	assign match_position = match_position_q;
	assign found          = found_q;
	assign fill_level     = fill_level_q;
	assign last           = last_q;

endmodule
`default_nettype wire

/* hdl/ise_cell.sv */
// One stack cell: a word register loaded from a neighbour, value or alt.
`timescale 1ns / 1ps
`default_nettype none
module ise_cell
	import ise_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_op_t              op,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic [DATA_WIDTH-1:0] alt,
	input  wire logic [DATA_WIDTH-1:0] below,
	input  wire logic [DATA_WIDTH-1:0] above,
	output logic [DATA_WIDTH-1:0]      word,
	output logic                       match
);

	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] word_d;

	always_comb begin
		unique case (op)
			CELL_HOLD:       word_d = word_q;
			CELL_LOAD_VALUE: word_d = value;
			CELL_LOAD_ALT:   word_d = alt;
			CELL_FROM_BELOW: word_d = below;
			CELL_FROM_ABOVE: word_d = above;
			CELL_CLEAR:      word_d = '0;
			default:         word_d = word_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= word_d;
		end
	end

	assign word  = word_q;
	assign match = (word_q == value);

endmodule
`default_nettype wire

/* hdl/ise_chain.sv */
// Row of stack cells with the per-cell operation decode and the read selection.
`timescale 1ns / 1ps
`default_nettype none
module ise_chain
	import ise_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire chain_cmd_t cmd,
	output chain_rsp_t      rsp
);

	logic [DATA_WIDTH-1:0] words  [DEPTH];
	logic [DATA_WIDTH-1:0] alts   [DEPTH];
	cell_op_t              ops    [DEPTH];
	logic [DEPTH-1:0]      hits;
	logic [POS_W-1:0]      pa_m1;
	logic [POS_W-1:0]      pb_m1;
	logic [POS_W-1:0]      top_m1;
	logic [DATA_WIDTH-1:0] word_b;

	assign pa_m1  = cmd.pos_a - POS_W'(1);
	assign pb_m1  = cmd.pos_b - POS_W'(1);
	assign top_m1 = cmd.fill - POS_W'(1);
	assign word_b = words[pb_m1[IDX_W-1:0]];

	assign rsp.word_a   = words[pa_m1[IDX_W-1:0]];
	assign rsp.word_top = words[top_m1[IDX_W-1:0]];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [POS_W-1:0] P = POS_W'(i + 1);
		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] above;
		logic                  cell_match;

		if (i == 0) begin : g_bottom
			assign below = '0;
		end else begin : g_inner_lo
			assign below = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign above = '0;
		end else begin : g_inner_hi
			assign above = words[i+1];
		end

		assign alts[i] = (P == cmd.pos_a) ? word_b : rsp.word_a;

		always_comb begin
			ops[i] = CELL_HOLD;
			if (cmd.en) begin
				unique case (cmd.func)
					FN_PUSH: begin
						if (P == cmd.fill + POS_W'(1)) ops[i] = CELL_LOAD_VALUE;
					end
					FN_POP: begin
						if (P == cmd.fill) ops[i] = CELL_CLEAR;
					end
					FN_INSERT: begin
						if (P == cmd.pos_a) begin
							ops[i] = CELL_LOAD_VALUE;
						end else if (P > cmd.pos_a && P <= cmd.fill + POS_W'(1)) begin
							ops[i] = CELL_FROM_BELOW;
						end
					end
					FN_REMOVE: begin
						if (P == cmd.fill) begin
							ops[i] = CELL_CLEAR;
						end else if (P >= cmd.pos_a && P < cmd.fill) begin
							ops[i] = CELL_FROM_ABOVE;
						end
					end
					FN_WRITE: begin
						if (P == cmd.pos_a) ops[i] = CELL_LOAD_VALUE;
					end
					FN_SWAP: begin
						if (P == cmd.pos_a || P == cmd.pos_b) ops[i] = CELL_LOAD_ALT;
					end
					FN_READ, FN_SEARCH: ops[i] = CELL_HOLD;
					default: ops[i] = CELL_HOLD;
				endcase
			end
		end

		ise_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (ops[i]),
			.value  (cmd.value),
			.alt    (alts[i]),
			.below  (below),
			.above  (above),
			.word   (words[i]),
			.match  (cell_match)
		);

		assign hits[i] = cell_match && (P <= cmd.fill);
	end

	assign rsp.match = hits;

endmodule
`default_nettype wire

/* hdl/ise_checker.sv */
// Port-level checks of the indexed stack engine and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ise_checker
	import ise_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CAP_W-1:0]      capacity,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic [FUNC_W-1:0]     func,
	input wire logic [POS_W-1:0]      position_a,
	input wire logic [POS_W-1:0]      position_b,
	input wire logic [DATA_WIDTH-1:0] value,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [STATUS_W-1:0]   status,
	input wire logic [DATA_WIDTH-1:0] data_out,
	input wire logic [POS_W-1:0]      match_position,
	input wire logic                  found,
	input wire logic [POS_W-1:0]      fill_level,
	input wire logic                  last
);

	// A stalled result transaction keeps its data, status, match position and last flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(status)
		&& $stable(match_position) && $stable(last))
		else $error("result changed while stalled");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_level <= POS_W'(DEPTH))
		else $error("fill level beyond depth");

	a_hit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> match_position != '0 && status == ST_OK && data_out == '0)
		else $error("malformed search hit");

	a_miss_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_position == '0 && last)
		else $error("result without hit must be single and final");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> data_out == '0)
		else $error("failed operation returned data");

endmodule

bind indexed_stack_engine ise_checker u_ise_checker (.*);
`default_nettype wire

/* bench/tb_indexed_stack_engine.sv */
// Self-checking testbench for the indexed stack engine with its own stack predictor.
`timescale 1ns / 1ps
module tb_indexed_stack_engine;
	import ise_pkg::*;

	localparam int PHASES        = 10;
	localparam int OPS_PER_PHASE = 41;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;

	localparam logic [PHASES-1:0][CAP_W-1:0] PHASE_CAP =
		{5'd16, 5'd0, 5'd2, 5'd16, 5'd12, 5'd3, 5'd16, 5'd31, 5'd0, 5'd1};
	localparam logic [PHASES-1:0][6:0] PHASE_GROW =
		{7'd20, 7'd50, 7'd50, 7'd30, 7'd50, 7'd40, 7'd70, 7'd80, 7'd50, 7'd50};

	typedef struct packed {
		func_t                 func;
		logic [POS_W-1:0]      pos_a;
		logic [POS_W-1:0]      pos_b;
		logic [DATA_WIDTH-1:0] word;
	} stack_op_t;

	typedef struct packed {
		status_t               status;
		logic [DATA_WIDTH-1:0] word;
		logic [POS_W-1:0]      match_pos;
		logic                  hit;
		logic [POS_W-1:0]      fill;
		logic                  last;
	} stack_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CAP_W-1:0]      capacity = CAP_RESET;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func = '0;
	logic [POS_W-1:0]      position_a = '0;
	logic [POS_W-1:0]      position_b = '0;
	logic [DATA_WIDTH-1:0] value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [DATA_WIDTH-1:0] data_out;
	logic [POS_W-1:0]      match_position;
	logic                  found;
	logic [POS_W-1:0]      fill_level;
	logic                  last;

	logic [DATA_WIDTH-1:0] model_cells [DEPTH] = '{default: '0};
	int                    model_fill = 0;
	int                    model_capacity = 16;

	stack_op_t             ops_to_send [$];
	stack_result_t         awaited_results [$];
	stack_op_t             live_op;
	stack_result_t         oldest;
	logic [DATA_WIDTH-1:0] word_pool [8];
	int                    fill_guess = 0;
	int                    guess_capacity = 16;
	int                    queued_ops = 0;
	int                    accepted_ops = 0;
	int                    send_wait = 0;
	int                    rx_wait = 0;
	int                    quiet_cycles = 0;
	int                    mismatches = 0;
	logic                  steady = 1'b0;

	indexed_stack_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.capacity       (capacity),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.position_a     (position_a),
		.position_b     (position_b),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.data_out       (data_out),
		.match_position (match_position),
		.found          (found),
		.fill_level     (fill_level),
		.last           (last)
	);

	always #1 clk = ~clk;

	task automatic predict_stack_op(input stack_op_t op);
		stack_result_t         res;
		int                    usable, pa, pb, i, hits, seen;
		logic                  a_ok, b_ok;
		logic [DATA_WIDTH-1:0] held;
		res = '0;
		res.status = ST_OK;
		res.last = 1'b1;
		hits = 0;
		usable = (model_capacity > DEPTH) ? DEPTH : model_capacity;
		pa = int'(op.pos_a);
		pb = int'(op.pos_b);
		a_ok = pa >= 1 && pa <= model_fill;
		b_ok = pb >= 1 && pb <= model_fill;
		case (op.func)
			FN_PUSH: begin
				if (model_fill >= usable) begin
					res.status = ST_FULL;
				end else begin
					model_cells[model_fill] = op.word;
					model_fill++;
				end
			end
			FN_POP: begin
				if (model_fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					model_fill--;
					res.word = model_cells[model_fill];
					model_cells[model_fill] = '0;
				end
			end
			FN_INSERT: begin
				if (model_fill >= usable) begin
					res.status = ST_FULL;
				end else if (pa < 1 || pa > model_fill + 1) begin
					res.status = ST_BADPOS;
				end else begin
					for (i = model_fill; i > pa - 1; i--)
						model_cells[i] = model_cells[i-1];
					model_cells[pa-1] = op.word;
					model_fill++;
				end
			end
			FN_REMOVE: begin
				if (model_fill == 0) begin
					res.status = ST_EMPTY;
				end else if (!a_ok) begin
					res.status = ST_BADPOS;
				end else begin
					for (i = pa - 1; i + 1 < model_fill; i++)
						model_cells[i] = model_cells[i+1];
					model_fill--;
					model_cells[model_fill] = '0;
				end
			end
			FN_READ: begin
				if (!a_ok)
					res.status = ST_BADPOS;
				else
					res.word = model_cells[pa-1];
			end
			FN_WRITE: begin
				if (!a_ok)
					res.status = ST_BADPOS;
				else
					model_cells[pa-1] = op.word;
			end
			FN_SWAP: begin
				if (!a_ok || !b_ok) begin
					res.status = ST_BADPOS;
				end else begin
					held = model_cells[pa-1];
					model_cells[pa-1] = model_cells[pb-1];
					model_cells[pb-1] = held;
				end
			end
			FN_SEARCH: begin
				for (i = 0; i < model_fill; i++)
					if (model_cells[i] == op.word)
						hits++;
				seen = 0;
				for (i = 0; i < model_fill; i++) begin
					if (model_cells[i] == op.word) begin
						seen++;
						res.hit = 1'b1;
						res.match_pos = POS_W'(i + 1);
						res.last = (seen == hits);
						res.fill = POS_W'(model_fill);
						awaited_results.push_back(res);
					end
				end
			end
		endcase
		if (hits == 0) begin
			res.fill = POS_W'(model_fill);
			awaited_results.push_back(res);
		end
	endtask

	function automatic stack_op_t mk_op(func_t f, int a, int b, logic [DATA_WIDTH-1:0] w);
		stack_op_t op;
		op.func = f;
		op.pos_a = POS_W'(a);
		op.pos_b = POS_W'(b);
		op.word = w;
		return op;
	endfunction

	function automatic stack_op_t random_op(int grow_pct);
		stack_op_t op;
		int        hi;
		hi = (fill_guess < 1) ? 1 : fill_guess;
		op.word = ($urandom_range(0, 9) < 7) ? word_pool[$urandom_range(0, 7)] : $urandom;
		op.pos_a = POS_W'($urandom_range(1, hi));
		op.pos_b = ($urandom_range(0, 5) == 0) ? op.pos_a : POS_W'($urandom_range(1, hi));
		op.func = FN_SEARCH;
		if ($urandom_range(0, 99) < 8) begin
			op.func = func_t'($urandom_range(0, 7));
			op.pos_a = POS_W'($urandom_range(0, 31));
			op.pos_b = POS_W'($urandom_range(0, 31));
			op.word = $urandom;
		end else if ($urandom_range(0, 99) < grow_pct) begin
			if ($urandom_range(0, 1)) begin
				op.func = FN_INSERT;
				op.pos_a = POS_W'($urandom_range(1, fill_guess + 1));
			end else begin
				op.func = FN_PUSH;
			end
		end else begin
			case ($urandom_range(0, 9))
				0, 1: op.func = FN_POP;
				2: op.func = FN_REMOVE;
				3: op.func = FN_READ;
				4: op.func = FN_WRITE;
				5, 6: op.func = FN_SWAP;
				default: op.func = FN_SEARCH;
			endcase
		end
		return op;
	endfunction

	task automatic send_op(input stack_op_t op);
		int usable;
		usable = (guess_capacity > DEPTH) ? DEPTH : guess_capacity;
		case (op.func)
			FN_PUSH: if (fill_guess < usable) fill_guess++;
			FN_INSERT: begin
				if (fill_guess < usable && op.pos_a >= 1 && op.pos_a <= fill_guess + 1)
					fill_guess++;
			end
			FN_POP: if (fill_guess > 0) fill_guess--;
			FN_REMOVE: if (op.pos_a >= 1 && op.pos_a <= fill_guess) fill_guess--;
			default: ;
		endcase
		ops_to_send.push_back(op);
		queued_ops++;
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		capacity <= cap;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		model_capacity = int'(cap);
		guess_capacity = int'(cap);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (accepted_ops != queued_ops || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_stack_op(live_op);
				accepted_ops++;
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (ops_to_send.size() > 0) begin
					live_op = ops_to_send.pop_front();
					func <= live_op.func;
					position_a <= live_op.pos_a;
					position_b <= live_op.pos_b;
					value <= live_op.word;
					in_valid <= 1'b1;
					send_wait = steady ? 0 : $urandom_range(0, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d data %h",
						$time, status, data_out);
					mismatches++;
				end else begin
					oldest = awaited_results.pop_front();
					mismatches += field_differs("status", 32'(oldest.status), 32'(status))
						+ field_differs("data_out", oldest.word, data_out)
						+ field_differs("match_position", 32'(oldest.match_pos),
							32'(match_position))
						+ field_differs("found", 32'(oldest.hit), 32'(found))
						+ field_differs("fill_level", 32'(oldest.fill), 32'(fill_level))
						+ field_differs("last", 32'(oldest.last), 32'(last));
				end
				rx_wait = steady ? 0 : $urandom_range(0, 8);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int               p, n;
		logic [CAP_W-1:0] cap;
		word_pool[0] = 32'h0000_0000;
		word_pool[1] = 32'hFFFF_FFFF;
		word_pool[2] = 32'h8000_0000;
		word_pool[3] = 32'h0000_0001;
		word_pool[4] = 32'hA5A5_A5A5;
		for (n = 5; n < 8; n++)
			word_pool[n] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_capacity(CAP_RESET);

		send_op(mk_op(FN_POP, 0, 0, 32'h0));
		send_op(mk_op(FN_REMOVE, 1, 0, 32'h0));
		send_op(mk_op(FN_READ, 1, 0, 32'h0));
		send_op(mk_op(FN_WRITE, 0, 0, 32'h5));
		send_op(mk_op(FN_SWAP, 1, 1, 32'h0));
		send_op(mk_op(FN_SEARCH, 0, 0, 32'h0));
		send_op(mk_op(FN_PUSH, 0, 0, 32'hFFFF_FFFF));
		send_op(mk_op(FN_PUSH, 0, 0, 32'h0));
		send_op(mk_op(FN_PUSH, 0, 0, 32'hA5A5_A5A5));
		send_op(mk_op(FN_INSERT, 1, 0, 32'hFFFF_FFFF));
		send_op(mk_op(FN_INSERT, 5, 0, 32'h1));
		send_op(mk_op(FN_INSERT, 0, 0, 32'h1));
		send_op(mk_op(FN_INSERT, 7, 0, 32'h7));
		send_op(mk_op(FN_READ, 5, 0, 32'h0));
		send_op(mk_op(FN_READ, 31, 0, 32'h0));
		send_op(mk_op(FN_WRITE, 2, 0, 32'h1234_5678));
		send_op(mk_op(FN_SWAP, 1, 5, 32'h0));
		send_op(mk_op(FN_SWAP, 3, 3, 32'h0));
		send_op(mk_op(FN_SWAP, 2, 6, 32'h0));
		send_op(mk_op(FN_SEARCH, 0, 0, 32'hFFFF_FFFF));
		send_op(mk_op(FN_SEARCH, 0, 0, 32'h0000_DEAD));
		send_op(mk_op(FN_REMOVE, 1, 0, 32'h0));
		send_op(mk_op(FN_REMOVE, 17, 0, 32'h0));
		send_op(mk_op(FN_POP, 0, 0, 32'h0));

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			cap = (p == 8) ? CAP_W'($urandom_range(0, 31)) : PHASE_CAP[p];
			write_capacity(cap);
			steady = (p == 3 || p == 7);
			for (n = 0; n < OPS_PER_PHASE; n++) begin
				if (p == 4 && n == OPS_PER_PHASE / 2)
					wait_drained();
				send_op(random_op(PHASE_GROW[p]));
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
